@@ sv/sparse_key_offset_table_defines.svh @@
// Assertion macros used by the sparse key offset table top level.
`ifndef SPARSE_KEY_OFFSET_TABLE_DEFINES_SVH
`define SPARSE_KEY_OFFSET_TABLE_DEFINES_SVH

`ifndef SYNTH
`define SKOT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SKOT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SKOT_ASSERT_IMP(lbl, ante, cons, msg)
`define SKOT_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ sv/skot_pkg.sv @@
// Types and constants shared by the sparse key offset table.
`timescale 1ns / 1ps
`default_nettype none

package skot_pkg;

	localparam int unsigned KEY_MAX_W = 24;
	localparam int unsigned OFF_W = 24;
	localparam int unsigned NT_W = 25;
	localparam int unsigned POS_W = 6;
	localparam int unsigned CAPACITY_DEF = 64;
	localparam int unsigned INDEX_BITS_DEF = 24;

	typedef enum logic [1:0] {
		FN_ASSOC = 2'd0,
		FN_FIND = 2'd1,
		FN_CREATE = 2'd2,
		FN_SORT = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_ABSENT = 2'd1,
		ST_FULL = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef struct packed {
		func_t func;
		logic [KEY_MAX_W-1:0] row;
		logic [KEY_MAX_W-1:0] col;
		logic [OFF_W-1:0] offset;
		logic [OFF_W-1:0] tent_offset;
	} req_t;

	typedef struct packed {
		status_t status;
		logic [OFF_W-1:0] result_offset;
		logic [NT_W-1:0] next_tentative;
		logic [KEY_MAX_W-1:0] key_row;
		logic [KEY_MAX_W-1:0] key_col;
		logic [POS_W-1:0] new_position;
		logic last;
	} rsp_t;

	typedef struct packed {
		logic vld;
		func_t func;
		logic [KEY_MAX_W-1:0] row;
		logic [KEY_MAX_W-1:0] col;
		logic [OFF_W-1:0] offset;
		logic [OFF_W-1:0] tent;
		logic hit;
		logic ins;
		logic [OFF_W-1:0] hit_off;
	} probe_t;

	typedef struct packed {
		logic vld;
		logic [KEY_MAX_W-1:0] row;
		logic [KEY_MAX_W-1:0] col;
	} rot_t;

	typedef struct packed {
		logic load;
		logic rot;
		logic wb;
		logic [POS_W-1:0] pos;
	} ctrl_t;

	typedef struct packed {
		logic hit;
		logic [KEY_MAX_W-1:0] row;
		logic [KEY_MAX_W-1:0] col;
		logic [OFF_W-1:0] off;
	} sel_t;

endpackage

`default_nettype wire

@@ sv/sparse_key_offset_table.sv @@
// Top level of the sparse key offset table: a chain of entry cells and its sequencer.
// Use: requests arrive on req/req_valid/req_stall and results leave on rsp/rsp_valid/rsp_stall.
// A transaction moves on a rising edge with valid high and stall low on that channel.
// One request is worked on at a time; req_stall stays high until its last result is
// placed in the output register, which then holds it while the next request is taken.
// Associate, find and create send a probe down the chain of CAPACITY cells, one cell
// per cycle, and each gives one result.
// Sort loads every key into a ring, rotates it CAPACITY times so each cell counts the
// smaller keys, then emits one result per entry in sorted order, one per cycle while
// the receiver does not stall, and rewrites each offset with its rank.
// A sort of an empty table gives a single result with the empty status.
// Reset empties the table at once; no clearing pass is needed.
// While rsp_stall is high with a valid result held, that result holds and the sequencer waits.
`timescale 1ns / 1ps
`default_nettype none
`include "sparse_key_offset_table_defines.svh"

module sparse_key_offset_table #(
	parameter int unsigned CAPACITY = skot_pkg::CAPACITY_DEF,
	parameter int unsigned INDEX_BITS = skot_pkg::INDEX_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  skot_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output skot_pkg::rsp_t rsp
);
	import skot_pkg::*;

	localparam int unsigned KEY_W = (INDEX_BITS < KEY_MAX_W) ? INDEX_BITS : KEY_MAX_W;
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PROBE,
		S_RESULT,
		S_LOAD,
		S_ROT,
		S_EMIT
	} state_t;

	state_t state_q;
	logic rsp_valid_q;
	rsp_t rsp_q;
	rsp_t pend_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] rot_cnt_q;
	logic [POS_W-1:0] pos_q;
	probe_t head_q;

	probe_t chain [CAPACITY+1];
	rot_t ring [CAPACITY];
	sel_t sel [CAPACITY];
	logic [CAPACITY-1:0] sel_vec;
	sel_t sel_or;
	ctrl_t ctrl;
	probe_t tail;
	probe_t head_d;
	rsp_t probe_rsp;
	rsp_t emit_rsp;
	rsp_t empty_rsp;
	logic can_load;
	logic rsp_load;
	logic emit_last;

	assign chain[0] = head_q;
	assign tail = chain[CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		skot_cell #(
			.KEY_W(KEY_W)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctrl(ctrl),
			.probe_in(chain[i]),
			.probe_out(chain[i+1]),
			.rot_in(ring[(i + CAPACITY - 1) % CAPACITY]),
			.rot_out(ring[i]),
			.sel(sel[i])
		);
		assign sel_vec[i] = sel[i].hit;
	end

	always_comb begin
		sel_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			sel_or = sel_t'(sel_or | sel[i]);
		end
	end

	assign can_load = !rsp_valid_q || !rsp_stall;
	assign rsp_load = ((state_q == S_RESULT) || (state_q == S_EMIT)) && can_load;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_comb begin
		ctrl.load = (state_q == S_LOAD);
		ctrl.rot = (state_q == S_ROT);
		ctrl.wb = (state_q == S_EMIT) && can_load;
		ctrl.pos = pos_q;
	end

	always_comb begin
		head_d.vld = (req.func != FN_SORT);
		head_d.func = req.func;
		head_d.row = KEY_MAX_W'(req.row[KEY_W-1:0]);
		head_d.col = KEY_MAX_W'(req.col[KEY_W-1:0]);
		head_d.offset = req.offset;
		head_d.tent = req.tent_offset;
		head_d.hit = 1'b0;
		head_d.ins = 1'b0;
		head_d.hit_off = '0;
	end

	always_comb begin
		probe_rsp = '0;
		probe_rsp.key_row = tail.row;
		probe_rsp.key_col = tail.col;
		probe_rsp.last = 1'b1;
		case (tail.func)
			FN_ASSOC: begin
				if (tail.hit || tail.ins) begin
					probe_rsp.status = ST_OK;
					probe_rsp.result_offset = tail.offset;
				end else begin
					probe_rsp.status = ST_FULL;
				end
			end
			FN_FIND: begin
				if (tail.hit) begin
					probe_rsp.status = ST_OK;
					probe_rsp.result_offset = tail.hit_off;
				end else begin
					probe_rsp.status = ST_ABSENT;
				end
			end
			FN_CREATE: begin
				if (tail.hit) begin
					probe_rsp.status = ST_OK;
					probe_rsp.result_offset = tail.hit_off;
					probe_rsp.next_tentative = NT_W'(tail.tent);
				end else if (tail.ins) begin
					probe_rsp.status = ST_OK;
					probe_rsp.result_offset = tail.tent;
					probe_rsp.next_tentative = NT_W'(tail.tent) + NT_W'(1);
				end else begin
					probe_rsp.status = ST_FULL;
					probe_rsp.next_tentative = NT_W'(tail.tent);
				end
			end
			default: begin
				probe_rsp.status = ST_OK;
			end
		endcase
	end

	always_comb begin
		emit_last = ((POS_W+1)'(pos_q) + (POS_W+1)'(1)) == (POS_W+1)'(cnt_q);
		emit_rsp = '0;
		emit_rsp.status = ST_OK;
		emit_rsp.result_offset = sel_or.off;
		emit_rsp.key_row = sel_or.row;
		emit_rsp.key_col = sel_or.col;
		emit_rsp.new_position = pos_q;
		emit_rsp.last = emit_last;
		empty_rsp = '0;
		empty_rsp.status = ST_EMPTY;
		empty_rsp.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp_valid_q <= 1'b0;
			cnt_q <= '0;
			rot_cnt_q <= '0;
			pos_q <= '0;
			head_q <= '0;
		end else begin
			rsp_valid_q <= rsp_load || (rsp_valid_q && rsp_stall);
			if ((state_q == S_IDLE) && req_valid) begin
				head_q <= head_d;
			end else begin
				head_q.vld <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						if (req.func == FN_SORT) begin
							if (cnt_q == '0) begin
								pend_q <= empty_rsp;
								state_q <= S_RESULT;
							end else begin
								state_q <= S_LOAD;
							end
						end else begin
							state_q <= S_PROBE;
						end
					end
				end
				S_PROBE: begin
					if (tail.vld) begin
						pend_q <= probe_rsp;
						if (tail.ins) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (can_load) begin
						rsp_q <= pend_q;
						state_q <= S_IDLE;
					end
				end
				S_LOAD: begin
					rot_cnt_q <= '0;
					state_q <= S_ROT;
				end
				S_ROT: begin
					rot_cnt_q <= rot_cnt_q + CNT_W'(1);
					if (rot_cnt_q == CNT_W'(CAPACITY - 1)) begin
						pos_q <= '0;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (can_load) begin
						rsp_q <= emit_rsp;
						pos_q <= pos_q + POS_W'(1);
						if (emit_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`SKOT_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= CNT_W'(CAPACITY), "entry count above capacity")
	`SKOT_ASSERT_IMP(a_emit_onehot, state_q == S_EMIT, $onehot(sel_vec), "sorted rank not unique")
	`SKOT_ASSERT_IMP(a_tail_in_probe, tail.vld, state_q == S_PROBE, "probe left chain out of phase")
	`SKOT_ASSERT_NXT(a_probe_start, req_valid && !req_stall && (req.func != FN_SORT), state_q == S_PROBE, "lookup did not start a probe")

endmodule

`default_nettype wire

@@ sv/skot_cell.sv @@
// One table cell: holds an entry, checks passing probes and ranks its key.
`timescale 1ns / 1ps
`default_nettype none

module skot_cell #(
	parameter int unsigned KEY_W = skot_pkg::INDEX_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  skot_pkg::ctrl_t  ctrl,
	input  skot_pkg::probe_t probe_in,
	output skot_pkg::probe_t probe_out,
	input  skot_pkg::rot_t   rot_in,
	output skot_pkg::rot_t   rot_out,
	output skot_pkg::sel_t   sel
);
	import skot_pkg::*;

	logic vld_q;
	logic [KEY_W-1:0] row_q;
	logic [KEY_W-1:0] col_q;
	logic [OFF_W-1:0] off_q;
	logic [POS_W-1:0] rank_q;
	probe_t probe_q;
	rot_t rot_q;

	logic match;
	logic take;
	logic less;
	logic chosen;
	probe_t probe_d;

	always_comb begin
		match = probe_in.vld && vld_q && (row_q == probe_in.row[KEY_W-1:0])
			&& (col_q == probe_in.col[KEY_W-1:0]);
		take = probe_in.vld && !vld_q && !probe_in.hit && !probe_in.ins
			&& ((probe_in.func == FN_ASSOC) || (probe_in.func == FN_CREATE));
		less = rot_q.vld && vld_q && ((rot_q.row[KEY_W-1:0] < row_q)
			|| ((rot_q.row[KEY_W-1:0] == row_q) && (rot_q.col[KEY_W-1:0] < col_q)));
		chosen = vld_q && (rank_q == ctrl.pos);
		probe_d = probe_in;
		if (match) begin
			probe_d.hit = 1'b1;
			probe_d.hit_off = off_q;
		end
		if (take) begin
			probe_d.ins = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			probe_q <= '0;
		end else begin
			probe_q <= probe_d;
			if (take) begin
				vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			row_q <= probe_in.row[KEY_W-1:0];
			col_q <= probe_in.col[KEY_W-1:0];
			off_q <= (probe_in.func == FN_ASSOC) ? probe_in.offset : probe_in.tent;
		end else if (match && (probe_in.func == FN_ASSOC)) begin
			off_q <= probe_in.offset;
		end else if (ctrl.wb && chosen) begin
			off_q <= OFF_W'(ctrl.pos);
		end
		if (ctrl.load) begin
			rank_q <= '0;
			rot_q.vld <= vld_q;
			rot_q.row <= KEY_MAX_W'(row_q);
			rot_q.col <= KEY_MAX_W'(col_q);
		end else if (ctrl.rot) begin
			if (less) begin
				rank_q <= rank_q + POS_W'(1);
			end
			rot_q <= rot_in;
		end
	end

	always_comb begin
		probe_out = probe_q;
		rot_out = rot_q;
		sel.hit = chosen;
		sel.row = chosen ? KEY_MAX_W'(row_q) : '0;
		sel.col = chosen ? KEY_MAX_W'(col_q) : '0;
		sel.off = chosen ? off_q : '0;
	end

endmodule

`default_nettype wire

@@ tb/sparse_key_offset_table_tb.sv @@
// Self-checking testbench of the sparse key offset table: directed rows, a full-table fill, then random traffic.
`timescale 1ns / 1ps
`default_nettype none

module sparse_key_offset_table_tb;
	import skot_pkg::*;

	localparam int CAP = 64;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	always #5 clk = ~clk;

	sparse_key_offset_table dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	// Shadow of the table contents.
	logic tbl_vld [CAP];
	logic [23:0] tbl_row [CAP];
	logic [23:0] tbl_col [CAP];
	logic [23:0] tbl_off [CAP];

	rsp_t pending_rsp [$];
	int mismatches = 0;
	int rsp_count = 0;
	int sorts_seen = 0;
	int fulls_seen = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_off = 1'b0;
	bit hold_off_go = 1'b0;

	function automatic rsp_t mk(status_t s, logic [23:0] ro, logic [24:0] nt,
			logic [23:0] kr, logic [23:0] kc, logic [5:0] np, logic l);
		rsp_t r;
		r.status = s; r.result_offset = ro; r.next_tentative = nt;
		r.key_row = kr; r.key_col = kc; r.new_position = np; r.last = l;
		return r;
	endfunction

	function automatic int table_find(logic [23:0] r, logic [23:0] c);
		for (int k = 0; k < CAP; k++)
			if (tbl_vld[k] && tbl_row[k] == r && tbl_col[k] == c)
				return k;
		return -1;
	endfunction

	function automatic int table_insert(logic [23:0] r, logic [23:0] c, logic [23:0] o);
		for (int k = 0; k < CAP; k++)
			if (!tbl_vld[k]) begin
				tbl_vld[k] = 1'b1; tbl_row[k] = r; tbl_col[k] = c; tbl_off[k] = o;
				return k;
			end
		return -1;
	endfunction

	function automatic bit key_lt(int a, int b);
		if (tbl_row[a] != tbl_row[b])
			return tbl_row[a] < tbl_row[b];
		return tbl_col[a] < tbl_col[b];
	endfunction

	task automatic predict_table(input req_t q);
		int k;
		int ord [$];
		int v, j, n;
		case (q.func)
			FN_ASSOC: begin
				k = table_find(q.row, q.col);
				if (k < 0)
					k = table_insert(q.row, q.col, q.offset);
				if (k < 0) begin
					pending_rsp.push_back(mk(ST_FULL, '0, '0, q.row, q.col, '0, 1'b1));
				end else begin
					tbl_off[k] = q.offset;
					pending_rsp.push_back(mk(ST_OK, q.offset, '0, q.row, q.col, '0, 1'b1));
				end
			end
			FN_FIND: begin
				k = table_find(q.row, q.col);
				if (k < 0)
					pending_rsp.push_back(mk(ST_ABSENT, '0, '0, q.row, q.col, '0, 1'b1));
				else
					pending_rsp.push_back(mk(ST_OK, tbl_off[k], '0, q.row, q.col, '0, 1'b1));
			end
			FN_CREATE: begin
				k = table_find(q.row, q.col);
				if (k >= 0)
					pending_rsp.push_back(mk(ST_OK, tbl_off[k], {1'b0, q.tent_offset},
						q.row, q.col, '0, 1'b1));
				else if (table_insert(q.row, q.col, q.tent_offset) >= 0)
					pending_rsp.push_back(mk(ST_OK, q.tent_offset,
						{1'b0, q.tent_offset} + 25'd1, q.row, q.col, '0, 1'b1));
				else
					pending_rsp.push_back(mk(ST_FULL, '0, {1'b0, q.tent_offset},
						q.row, q.col, '0, 1'b1));
			end
			default: begin
				for (k = 0; k < CAP; k++)
					if (tbl_vld[k])
						ord.push_back(k);
				n = ord.size();
				if (n == 0) begin
					pending_rsp.push_back(mk(ST_EMPTY, '0, '0, '0, '0, '0, 1'b1));
				end else begin
					for (int i = 1; i < n; i++) begin
						v = ord[i];
						j = i - 1;
						while (j >= 0 && key_lt(v, ord[j])) begin
							ord[j + 1] = ord[j];
							j--;
						end
						ord[j + 1] = v;
					end
					for (int i = 0; i < n; i++) begin
						pending_rsp.push_back(mk(ST_OK, tbl_off[ord[i]], '0, tbl_row[ord[i]],
							tbl_col[ord[i]], i[5:0], i == n - 1));
						tbl_off[ord[i]] = i[23:0];
					end
				end
			end
		endcase
	endtask

	function automatic req_t mkreq(func_t f, logic [23:0] r, logic [23:0] c,
			logic [23:0] o, logic [23:0] t);
		req_t q;
		q.func = f; q.row = r; q.col = c; q.offset = o; q.tent_offset = t;
		return q;
	endfunction

	// Sends one transaction after a random idle gap and updates the prediction.
	task automatic send(input req_t q);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= q;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		predict_table(q);
	endtask

	task automatic drain;
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (CAP * 3) @(posedge clk);
	endtask

	// Random key drawn from a small pool so that hits, duplicates and sort ties are common.
	function automatic logic [23:0] pool_val(int sel);
		case (sel)
			0: return 24'h000000;
			1: return 24'hFFFFFF;
			default: return 24'($urandom_range(7));
		endcase
	endfunction

	function automatic req_t rand_req;
		func_t f;
		logic [23:0] r, c;
		int p;
		p = $urandom_range(99);
		f = p < 30 ? FN_ASSOC : p < 55 ? FN_FIND : p < 93 ? FN_CREATE : FN_SORT;
		if ($urandom_range(3) == 0) begin
			r = 24'($urandom); c = 24'($urandom);
		end else begin
			r = pool_val($urandom_range(9)); c = pool_val($urandom_range(9));
		end
		return mkreq(f, r, c, 24'($urandom), 24'($urandom));
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("sparse_key_offset_table verification failed");
			$finish;
		end
	end

	// Receiver stall, including one long hold-off that backs the block up.
	initial begin
		int hold;
		forever begin
			@(posedge clk);
			if (hold_off_go && !hold_off) begin
				hold_off = 1'b1;
				rsp_stall <= 1'b1;
				for (hold = 0; hold < 600; hold++)
					@(posedge clk);
			end
			rsp_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			rsp_count++;
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", rsp);
			end else begin
				e = pending_rsp.pop_front();
				if (e.status == ST_FULL)
					fulls_seen++;
				if (e.last && e.new_position != 0 || e.status == ST_EMPTY)
					sorts_seen++;
				if (rsp !== e) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", e, rsp);
				end
			end
		end
	end

	typedef struct {
		req_t q;
		bit has_rsp;
		rsp_t r;
	} dir_row_t;

	initial begin
		dir_row_t rows [$];
		for (int k = 0; k < CAP; k++) begin
			tbl_vld[k] = 1'b0; tbl_row[k] = '0; tbl_col[k] = '0; tbl_off[k] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows.push_back('{mkreq(FN_SORT, 24'h123456, 24'h654321, '1, '1), 1'b1,
			mk(ST_EMPTY, '0, '0, '0, '0, '0, 1'b1)});
		rows.push_back('{mkreq(FN_FIND, '1, '1, '1, '1), 1'b1,
			mk(ST_ABSENT, '0, '0, '1, '1, '0, 1'b1)});
		rows.push_back('{mkreq(FN_CREATE, '1, '1, '0, '1), 1'b1,
			mk(ST_OK, '1, 25'h1000000, '1, '1, '0, 1'b1)});
		rows.push_back('{mkreq(FN_ASSOC, '0, '0, '1, '0), 1'b1,
			mk(ST_OK, '1, '0, '0, '0, '0, 1'b1)});
		rows.push_back('{mkreq(FN_CREATE, '0, '0, '0, 24'h000005), 1'b1,
			mk(ST_OK, '1, 25'd5, '0, '0, '0, 1'b1)});
		rows.push_back('{mkreq(FN_ASSOC, '0, '0, 24'h00ABCD, '1), 1'b0, '0});
		rows.push_back('{mkreq(FN_FIND, '0, '0, '0, '0), 1'b0, '0});
		rows.push_back('{mkreq(FN_CREATE, '0, '1, 24'h1, 24'h7FFFFE), 1'b0, '0});
		rows.push_back('{mkreq(FN_SORT, '0, '0, '0, '0), 1'b0, '0});
		rows.push_back('{mkreq(FN_FIND, '1, '1, '0, '0), 1'b0, '0});
		foreach (rows[i]) begin
			send(rows[i].q);
			if (rows[i].has_rsp) begin
				// Typed-in values stand in for the prediction of this row.
				void'(pending_rsp.pop_back());
				pending_rsp.push_back(rows[i].r);
			end
		end
		drain();

		// Fill the table to capacity, then push past it with both insert operations.
		for (int k = 0; k < CAP + 2; k++)
			send(mkreq(FN_CREATE, 24'($urandom_range(3) << 22 | k), 24'($urandom),
				24'($urandom), 24'($urandom)));
		send(mkreq(FN_ASSOC, 24'hFFFFFE, 24'h0, 24'h1, 24'h0));
		send(mkreq(FN_CREATE, 24'hFFFFFE, 24'h1, 24'h0, '1));
		send(mkreq(FN_SORT, '0, '0, '0, '0));
		drain();

		// Hold off the receiver for a long stretch while requests keep coming.
		hold_off_go = 1'b1;
		for (int n = 0; n < 10; n++)
			send(rand_req());
		drain();

		// The table stays full for the random part: known keys hit, new keys are refused,
		// and sorts renumber the entries.
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = phase == 0 ? 19 : phase == 1 ? 49 : 0;
			recv_idle_pct = phase == 0 ? 49 : phase == 1 ? 19 : 0;
			for (int n = 0; n < 27; n++)
				send(rand_req());
			drain();
		end

		$display("covered directed extremes, full-table inserts, %0d sort or empty ends,",
			sorts_seen);
		$display("%0d full results, %0d results checked in all", fulls_seen, rsp_count);
		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("sparse_key_offset_table verification clean");
		else
			$display("sparse_key_offset_table verification failed");
		$finish;
	end

endmodule

`default_nettype wire
